[sv/pid_timestamped_dt_assert.svh]
// ---------------------------------------------------------------------------
// pid_timestamped_dt_assert.svh
// assertion macros used by pidt_ctrl, clocked on i_clk
// ---------------------------------------------------------------------------
`ifndef PID_TIMESTAMPED_DT_ASSERT_SVH
`define PID_TIMESTAMPED_DT_ASSERT_SVH

// same-cycle implication
`define PIDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PIDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pidt_pkg.sv]
// ---------------------------------------------------------------------------
// pidt_pkg
// types, constants and codes shared by the pid step modules
// ---------------------------------------------------------------------------
package pidt_pkg;

    localparam int DATA_W        = 32;
    localparam int STAMP_W       = 24;
    localparam int FRAC_W        = 16;
    localparam int TICKS_PER_US  = 9;
    localparam int TIMER_RELOAD  = 16777215;
    localparam int ONE_SEC       = TICKS_PER_US * 1000000;
    localparam int MAX_TICKS     = TICKS_PER_US * 50000;
    localparam int DEFAULT_TICKS = TICKS_PER_US * 1000;
    localparam int TICKS_W       = $clog2(MAX_TICKS + 1);
    localparam int SEC_W         = $clog2(ONE_SEC + 1);
    localparam int MB_W          = (TICKS_W > SEC_W) ? TICKS_W : SEC_W;
    localparam int TK_W          = STAMP_W + 2;
    // magnitude of a 32x32 signed product
    localparam int MAG_W         = 2 * DATA_W - 1;
    localparam int NUM_W         = MAG_W + MB_W;
    localparam int DEN_W         = MB_W + FRAC_W;
    localparam int QUO_W         = 48;
    localparam int DIV_ITER      = QUO_W / 2;
    localparam int PTERM_W       = 2 * DATA_W - FRAC_W;
    localparam int ISUM_W        = QUO_W + 2;
    localparam int SUM_W         = PTERM_W + 3;
    localparam int DRV_W         = SUM_W + 1;
    localparam int MUL_W         = DATA_W + 1;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP        = 3'd0,
        REG_KI        = 3'd1,
        REG_KD        = 3'd2,
        REG_INT_UPPER = 3'd3,
        REG_INT_LOWER = 3'd4,
        REG_DRV_UPPER = 3'd5,
        REG_DRV_LOWER = 3'd6,
        REG_OFFSET    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] kp_gain;
        logic signed [DATA_W-1:0] ki_gain;
        logic signed [DATA_W-1:0] kd_gain;
        logic signed [DATA_W-1:0] integral_upper;
        logic signed [DATA_W-1:0] integral_lower;
        logic signed [DATA_W-1:0] drive_upper;
        logic signed [DATA_W-1:0] drive_lower;
        logic signed [DATA_W-1:0] deadband_offset;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MP,
        OP_MI,
        OP_MD,
        OP_MIL,
        OP_MIH,
        OP_DIVI,
        OP_CAPI,
        OP_MDL,
        OP_MDH,
        OP_DIVD,
        OP_CAPD,
        OP_INT,
        OP_SUM,
        OP_OUT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MP,
        S_MI,
        S_MD,
        S_MIL,
        S_MIH,
        S_DIVI_GO,
        S_DIVI_WAIT,
        S_MDL,
        S_MDH,
        S_DIVD_GO,
        S_DIVD_WAIT,
        S_INT,
        S_SUM,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

[sv/pidt_div.sv]
// ---------------------------------------------------------------------------
// pidt_div
// radix-4 restoring divider, two quotient bits a cycle, saturating quotient
// ---------------------------------------------------------------------------
module pidt_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pidt_pkg::NUM_W-1:0] i_num,
    input  logic [pidt_pkg::DEN_W-1:0] i_den,
    output logic                       o_done,
    output logic [pidt_pkg::QUO_W-1:0] o_quo
);
    import pidt_pkg::*;

    localparam int CNT_W = $clog2(DIV_ITER);

    logic [DEN_W-1:0] r_rem, n_rem;
    logic [QUO_W-1:0] r_sh, n_sh;
    logic [QUO_W-1:0] r_q, n_q;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_ovf;
    logic [DEN_W:0]   trial;
    logic             ovf;

    // quotient too wide when the top part of the numerator already reaches the divisor
    assign ovf = DEN_W'(i_num[NUM_W-1:QUO_W]) >= i_den;

    always_comb begin
        n_rem = r_rem;
        n_sh  = r_sh;
        n_q   = r_q;
        trial = '0;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_sh[QUO_W-1]};
            n_sh  = {n_sh[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial = trial - {1'b0, r_den};
                n_q   = {n_q[QUO_W-2:0], 1'b1};
            end else begin
                n_q   = {n_q[QUO_W-2:0], 1'b0};
            end
            n_rem = trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_W'(i_num[NUM_W-1:QUO_W]);
            r_sh  <= i_num[QUO_W-1:0];
            r_q   <= '0;
            r_den <= i_den;
            r_ovf <= ovf;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh  <= n_sh;
            r_q   <= n_q;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_ovf ? {QUO_W{1'b1}} : r_q;

endmodule

[sv/pidt_dp.sv]
// ---------------------------------------------------------------------------
// pidt_dp
// datapath: interval, shared multiplier, divider, integral, drive and output
// ---------------------------------------------------------------------------
module pidt_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pidt_pkg::t_cmd                      i_cmd,
    output pidt_pkg::t_sts                      o_sts,
    input  pidt_pkg::t_cfg                      i_cfg,
    input  logic signed [pidt_pkg::DATA_W-1:0]  i_setpoint,
    input  logic signed [pidt_pkg::DATA_W-1:0]  i_measured,
    input  logic [pidt_pkg::STAMP_W-1:0]        i_tick_stamp,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [pidt_pkg::DATA_W-1:0]  o_drive,
    output logic                                o_interval_defaulted,
    output logic                                o_drive_clamped
);
    import pidt_pkg::*;

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        if (v[DATA_W] != v[DATA_W-1])
            return v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        return v[DATA_W-1:0];
    endfunction

    // state kept across items
    logic [STAMP_W-1:0]        r_last;
    logic signed [DATA_W-1:0]  r_prev;
    logic signed [DATA_W-1:0]  r_int;

    // per-item working registers
    logic [TICKS_W-1:0]        r_ticks;
    logic                      r_def;
    logic signed [DATA_W-1:0]  r_err;
    logic signed [DATA_W-1:0]  r_dmeas;
    logic signed [2*DATA_W-1:0] r_prod_p;
    logic [MAG_W-1:0]          r_mag_i;
    logic [MAG_W-1:0]          r_mag_d;
    logic                      r_neg_i;
    logic                      r_neg_d;
    logic [2*DATA_W-1:0]       r_acc;
    logic [NUM_W-1:0]          r_num;
    logic [QUO_W-1:0]          r_q_i;
    logic [QUO_W-1:0]          r_q_d;
    logic signed [PTERM_W-1:0] r_pterm;
    logic signed [SUM_W-1:0]   r_sum;

    // output register
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_drive;
    logic                      r_out_def;
    logic                      r_clamped;

    logic signed [TK_W-1:0]    tk_raw;
    logic                      tk_def;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic [2*DATA_W-1:0]       mag_full;
    logic                      out_free;
    logic [DEN_W-1:0]          div_den;
    logic                      div_done;
    logic [QUO_W-1:0]          div_quo;
    logic signed [2*DATA_W-1:0] p_adj;
    logic signed [QUO_W:0]     inc;
    logic signed [ISUM_W-1:0]  isum;
    logic signed [QUO_W:0]     dterm;
    logic signed [DRV_W-1:0]   drv;
    logic signed [DRV_W-1:0]   drv_c;
    logic                      c_up, c_lo;

    // elapsed ticks on a down-counter, wrap adds the reload span
    always_comb begin
        if (i_tick_stamp <= r_last)
            tk_raw = $signed({2'b00, r_last - i_tick_stamp});
        else
            tk_raw = $signed({2'b00, r_last}) + $signed(TK_W'(TIMER_RELOAD))
                   - $signed({2'b00, i_tick_stamp});
        tk_def = (tk_raw <= 0) || (tk_raw > $signed(TK_W'(MAX_TICKS)));
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_MP: begin
                mul_a = MUL_W'(i_cfg.kp_gain);
                mul_b = MUL_W'(r_err);
            end
            OP_MI: begin
                mul_a = MUL_W'(i_cfg.ki_gain);
                mul_b = MUL_W'(r_err);
            end
            OP_MD: begin
                mul_a = MUL_W'(i_cfg.kd_gain);
                mul_b = MUL_W'(r_dmeas);
            end
            OP_MIL: begin
                mul_a = $signed({1'b0, r_mag_i[DATA_W-1:0]});
                mul_b = $signed(MUL_W'(r_ticks));
            end
            OP_MIH: begin
                mul_a = $signed(MUL_W'(r_mag_i[MAG_W-1:DATA_W]));
                mul_b = $signed(MUL_W'(r_ticks));
            end
            OP_MDL: begin
                mul_a = $signed({1'b0, r_mag_d[DATA_W-1:0]});
                mul_b = $signed(MUL_W'(ONE_SEC));
            end
            OP_MDH: begin
                mul_a = $signed(MUL_W'(r_mag_d[MAG_W-1:DATA_W]));
                mul_b = $signed(MUL_W'(ONE_SEC));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p    = mul_a * mul_b;
        mag_full = mul_p[2*DATA_W-1] ? (~mul_p[2*DATA_W-1:0] + 1'b1) : mul_p[2*DATA_W-1:0];
    end

    assign div_den = (i_cmd.op == OP_DIVI) ? DEN_W'(ONE_SEC) << FRAC_W
                                           : DEN_W'(r_ticks) << FRAC_W;

    pidt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // integral, proportional, derivative and final drive arithmetic
    always_comb begin
        p_adj = r_prod_p + (r_prod_p[2*DATA_W-1] ? 64'sd65535 : 64'sd0);
        inc   = r_neg_i ? -$signed({1'b0, r_q_i}) : $signed({1'b0, r_q_i});
        isum  = ISUM_W'(r_int) + ISUM_W'(inc);
        if (isum > ISUM_W'(i_cfg.integral_upper))
            isum = ISUM_W'(i_cfg.integral_upper);
        if (isum < ISUM_W'(i_cfg.integral_lower))
            isum = ISUM_W'(i_cfg.integral_lower);
        if (i_cfg.ki_gain == '0)
            isum = '0;
        dterm = r_neg_d ? -$signed({1'b0, r_q_d}) : $signed({1'b0, r_q_d});

        if (r_sum > 0)
            drv = DRV_W'(r_sum) + DRV_W'(i_cfg.deadband_offset);
        else if (r_sum < 0)
            drv = DRV_W'(r_sum) - DRV_W'(i_cfg.deadband_offset);
        else
            drv = DRV_W'(r_sum);
        c_up  = drv > DRV_W'(i_cfg.drive_upper);
        drv_c = c_up ? DRV_W'(i_cfg.drive_upper) : drv;
        c_lo  = drv_c < DRV_W'(i_cfg.drive_lower);
        if (c_lo)
            drv_c = DRV_W'(i_cfg.drive_lower);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_prev <= '0;
            r_int  <= '0;
        end else begin
            if (i_cmd.op == OP_LOAD) begin
                r_last <= i_tick_stamp;
                r_prev <= i_measured;
            end
            if (i_cmd.op == OP_INT)
                r_int <= isum[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_ticks <= tk_def ? TICKS_W'(DEFAULT_TICKS) : tk_raw[TICKS_W-1:0];
                r_def   <= tk_def;
                r_err   <= sat33((DATA_W+1)'(i_setpoint) - (DATA_W+1)'(i_measured));
                r_dmeas <= sat33((DATA_W+1)'(i_measured) - (DATA_W+1)'(r_prev));
            end
            OP_MP:   r_prod_p <= mul_p[2*DATA_W-1:0];
            OP_MI: begin
                r_mag_i <= mag_full[MAG_W-1:0];
                r_neg_i <= mul_p[2*DATA_W-1];
            end
            OP_MD: begin
                r_mag_d <= mag_full[MAG_W-1:0];
                r_neg_d <= mul_p[2*DATA_W-1];
            end
            OP_MIL, OP_MDL: r_acc <= mul_p[2*DATA_W-1:0];
            OP_MIH, OP_MDH: r_num <= NUM_W'(r_acc)
                                   + (NUM_W'(mul_p[2*DATA_W-2:0]) << DATA_W);
            OP_CAPI: if (div_done) r_q_i <= div_quo;
            OP_CAPD: if (div_done) r_q_d <= div_quo;
            OP_INT:  r_pterm <= p_adj[2*DATA_W-1:FRAC_W];
            OP_SUM:  r_sum <= SUM_W'(r_pterm) + SUM_W'(r_int) - SUM_W'(dterm);
            default: ;
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT && out_free) begin
            r_drive   <= drv_c[DATA_W-1:0];
            r_out_def <= r_def;
            r_clamped <= c_up || c_lo;
        end
    end

    assign o_sts.div_done       = div_done;
    assign o_sts.out_free       = out_free;
    assign o_out_valid          = r_out_valid;
    assign o_drive              = r_drive;
    assign o_interval_defaulted = r_out_def;
    assign o_drive_clamped      = r_clamped;

endmodule

[sv/pidt_ctrl.sv]
// ---------------------------------------------------------------------------
// pidt_ctrl
// sequencer for one pid step: multiplies, two divisions, integral and drive
// ---------------------------------------------------------------------------
`include "pid_timestamped_dt_assert.svh"

module pidt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  pidt_pkg::t_sts i_sts,
    output pidt_pkg::t_cmd o_cmd
);
    import pidt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_MP;
            S_MP:        n_state = S_MI;
            S_MI:        n_state = S_MD;
            S_MD:        n_state = S_MIL;
            S_MIL:       n_state = S_MIH;
            S_MIH:       n_state = S_DIVI_GO;
            S_DIVI_GO:   n_state = S_DIVI_WAIT;
            S_DIVI_WAIT: if (i_sts.div_done) n_state = S_MDL;
            S_MDL:       n_state = S_MDH;
            S_MDH:       n_state = S_DIVD_GO;
            S_DIVD_GO:   n_state = S_DIVD_WAIT;
            S_DIVD_WAIT: if (i_sts.div_done) n_state = S_INT;
            S_INT:       n_state = S_SUM;
            S_SUM:       n_state = S_OUT;
            S_OUT:       if (i_sts.out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op        = OP_NONE;
        o_cmd.div_start = 1'b0;
        case (r_state)
            S_IDLE:      o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_MP:        o_cmd.op = OP_MP;
            S_MI:        o_cmd.op = OP_MI;
            S_MD:        o_cmd.op = OP_MD;
            S_MIL:       o_cmd.op = OP_MIL;
            S_MIH:       o_cmd.op = OP_MIH;
            S_DIVI_GO: begin
                o_cmd.op        = OP_DIVI;
                o_cmd.div_start = 1'b1;
            end
            S_DIVI_WAIT: o_cmd.op = OP_CAPI;
            S_MDL:       o_cmd.op = OP_MDL;
            S_MDH:       o_cmd.op = OP_MDH;
            S_DIVD_GO: begin
                o_cmd.op        = OP_DIVD;
                o_cmd.div_start = 1'b1;
            end
            S_DIVD_WAIT: o_cmd.op = OP_CAPD;
            S_INT:       o_cmd.op = OP_INT;
            S_SUM:       o_cmd.op = OP_SUM;
            S_OUT:       o_cmd.op = OP_OUT;
            default:     o_cmd.op = OP_NONE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    `PIDT_ASSERT_NEXT(a_accept_starts, r_state == S_IDLE && i_in_valid, r_state == S_MP, "accepted item did not start")
    `PIDT_ASSERT_NEXT(a_divi_holds, r_state == S_DIVI_WAIT && !i_sts.div_done, r_state == S_DIVI_WAIT, "left integral division early")
    `PIDT_ASSERT_NEXT(a_divd_holds, r_state == S_DIVD_WAIT && !i_sts.div_done, r_state == S_DIVD_WAIT, "left derivative division early")
    `PIDT_ASSERT_NEXT(a_out_holds, r_state == S_OUT && !i_sts.out_free, r_state == S_OUT, "result dropped while output full")

endmodule

[sv/pid_timestamped_dt.sv]
// ---------------------------------------------------------------------------
// pid_timestamped_dt
// PID step with a tick-stamp derived interval, derivative on measurement.
// One item at a time: after an item is accepted the input stalls until the
// step has put its result into the output register. The step makes two
// passes of the shared radix-4 divider (24 iterations each), integral
// scaling by the interval and then derivative over the interval; besides
// these it makes seven passes of the shared 33x33 multiplier, a start step
// for each division and the integral, sum and clamp steps. The result
// waits in an output register, so the next item is taken while it is still
// unread; a result that is still held when the next one is ready stalls the
// step until it is read. Setpoint, measurement, gains, limits, offset and
// drive are signed Q16.16; configuration writes are taken every cycle.
// ---------------------------------------------------------------------------
module pid_timestamped_dt (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [pidt_pkg::DATA_W-1:0]    i_setpoint,
    input  logic signed [pidt_pkg::DATA_W-1:0]    i_measured,
    input  logic [pidt_pkg::STAMP_W-1:0]          i_tick_stamp,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [pidt_pkg::DATA_W-1:0]    o_drive,
    output logic                                  o_interval_defaulted,
    output logic                                  o_drive_clamped,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pidt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pidt_pkg::DATA_W-1:0]           i_cfg_data
);
    import pidt_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_KP:        r_cfg.kp_gain         <= i_cfg_data;
                REG_KI:        r_cfg.ki_gain         <= i_cfg_data;
                REG_KD:        r_cfg.kd_gain         <= i_cfg_data;
                REG_INT_UPPER: r_cfg.integral_upper  <= i_cfg_data;
                REG_INT_LOWER: r_cfg.integral_lower  <= i_cfg_data;
                REG_DRV_UPPER: r_cfg.drive_upper     <= i_cfg_data;
                REG_DRV_LOWER: r_cfg.drive_lower     <= i_cfg_data;
                REG_OFFSET:    r_cfg.deadband_offset <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    pidt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pidt_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_cfg                (r_cfg),
        .i_setpoint           (i_setpoint),
        .i_measured           (i_measured),
        .i_tick_stamp         (i_tick_stamp),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_drive              (o_drive),
        .o_interval_defaulted (o_interval_defaulted),
        .o_drive_clamped      (o_drive_clamped)
    );

endmodule

[verif/pid_timestamped_dt_test.sv]
// ---------------------------------------------------------------------------
// pid_timestamped_dt_test
// self-checking bench for the timestamped pid step: a directed pass over the
// interval, limit and field corner cases, then random control sequences
// under several gain settings, all but the last with random idling on both channels
// ---------------------------------------------------------------------------
module pid_timestamped_dt_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pidt_pkg::*;

    localparam longint unsigned U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 800000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [DATA_W-1:0]  i_setpoint;
    logic signed [DATA_W-1:0]  i_measured;
    logic [STAMP_W-1:0]        i_tick_stamp;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [DATA_W-1:0]  o_drive;
    logic                      o_interval_defaulted;
    logic                      o_drive_clamped;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [DATA_W-1:0]         i_cfg_data;

    pid_timestamped_dt DUT (.*);

    typedef struct {
        logic [DATA_W-1:0] drive;
        logic              defaulted;
        logic              clamped;
    } t_step_out;

    // controller copy
    longint             gain_cfg [8];
    logic [STAMP_W-1:0] prev_stamp;
    longint             prev_meas;
    longint             integ;

    t_step_out pending_steps[$];
    int        fail_count;
    int        cycle_count;
    bit        idle_en;
    int        hold_left;
    int        stall_left;
    logic [STAMP_W-1:0] stamp_gen;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    // floor(a*m/d), saturating
    function automatic longint unsigned scale_div(longint unsigned a, longint unsigned m,
                                                  longint unsigned d);
        longint unsigned q, r, hi, lo;
        q = a / d;
        r = a % d;
        if (q != 0 && q > U64_MAX / m) return U64_MAX;
        hi = q * m;
        lo = (r * m) / d;
        if (hi > U64_MAX - lo) return U64_MAX;
        return hi + lo;
    endfunction

    function automatic t_step_out pid_step(longint sp, longint ms, logic [STAMP_W-1:0] st);
        t_step_out res;
        longint ticks, err, dmeas, prod, pterm, dterm, drv, inc, sum;
        longint unsigned m;
        res.defaulted = 1'b0;
        res.clamped   = 1'b0;
        if (st <= prev_stamp) ticks = longint'(prev_stamp) - longint'(st);
        else ticks = longint'(prev_stamp) + (longint'(TIMER_RELOAD) - longint'(st));
        if (ticks <= 0 || ticks > MAX_TICKS) begin
            ticks = DEFAULT_TICKS;
            res.defaulted = 1'b1;
        end
        prev_stamp = st;
        err = sat32(sp - ms);
        if (gain_cfg[REG_KI] != 0) begin
            prod = gain_cfg[REG_KI] * err;
            m = scale_div(magnitude(prod), ticks, ONE_SEC) / 65536;
            inc = prod < 0 ? -longint'(m) : longint'(m);
            sum = integ + inc;
            if (sum > gain_cfg[REG_INT_UPPER]) sum = gain_cfg[REG_INT_UPPER];
            if (sum < gain_cfg[REG_INT_LOWER]) sum = gain_cfg[REG_INT_LOWER];
            integ = sum;
        end else begin
            integ = 0;
        end
        pterm = (gain_cfg[REG_KP] * err) / 65536;
        dmeas = sat32(ms - prev_meas);
        prod = gain_cfg[REG_KD] * dmeas;
        m = scale_div(magnitude(prod), ONE_SEC, ticks) / 65536;
        dterm = prod < 0 ? -longint'(m) : longint'(m);
        drv = pterm + integ - dterm;
        if (drv > 0) drv = drv + gain_cfg[REG_OFFSET];
        else if (drv < 0) drv = drv - gain_cfg[REG_OFFSET];
        if (drv > gain_cfg[REG_DRV_UPPER]) begin
            drv = gain_cfg[REG_DRV_UPPER];
            res.clamped = 1'b1;
        end
        if (drv < gain_cfg[REG_DRV_LOWER]) begin
            drv = gain_cfg[REG_DRV_LOWER];
            res.clamped = 1'b1;
        end
        prev_meas = ms;
        res.drive = drv[DATA_W-1:0];
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_step_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_steps.size() == 0) begin
                $error("unexpected result item, drive %h", o_drive);
                fail_count++;
            end else begin
                want = pending_steps.pop_front();
                if (o_drive !== want.drive) begin
                    $error("drive: expected %h, got %h", want.drive, o_drive);
                    fail_count++;
                end
                if (o_interval_defaulted !== want.defaulted) begin
                    $error("interval_defaulted: expected %b, got %b", want.defaulted,
                           o_interval_defaulted);
                    fail_count++;
                end
                if (o_drive_clamped !== want.clamped) begin
                    $error("drive_clamped: expected %b, got %b", want.clamped,
                           o_drive_clamped);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall, long hold counted here
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(0, 5);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // all tasks start and end at a falling edge
    task automatic send_item(logic [31:0] sp, logic [31:0] ms, logic [STAMP_W-1:0] st);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_setpoint   <= sp;
        i_measured   <= ms;
        i_tick_stamp <= st;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_steps.push_back(pid_step(longint'(signed'(sp)), longint'(signed'(ms)), st));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        gain_cfg[idx] = longint'(signed'(val));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_gains(logic [31:0] kp, ki, kd, iu, il, du, dl, off);
        drain();
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_INT_UPPER, iu);
        write_reg(REG_INT_LOWER, il);
        write_reg(REG_DRV_UPPER, du);
        write_reg(REG_DRV_LOWER, dl);
        write_reg(REG_OFFSET, off);
    endtask

    function automatic logic [STAMP_W-1:0] next_stamp();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80) stamp_gen = stamp_gen - STAMP_W'($urandom_range(1, MAX_TICKS));
        else if (sel < 85) stamp_gen = stamp_gen;
        else if (sel < 90) stamp_gen = stamp_gen - STAMP_W'($urandom_range(MAX_TICKS + 1,
                                                                            4000000));
        else stamp_gen = STAMP_W'($urandom);
        return stamp_gen;
    endfunction

    task automatic random_gains(bit wild);
        logic [31:0] iu, il, du, dl;
        if (wild) begin
            set_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        end else begin
            iu = $urandom_range(0, 32'h0100_0000);
            il = -$urandom_range(0, 32'h0100_0000);
            du = $urandom_range(32'h0001_0000, 32'h0800_0000);
            dl = -$urandom_range(32'h0001_0000, 32'h0800_0000);
            // crossed limits now and then
            if ($urandom_range(0, 7) == 0) begin
                iu = -32'h0001_0000;
                dl = du + 32'h100;
            end
            set_gains($urandom_range(0, 32'h0008_0000) - 32'h0004_0000,
                      ($urandom_range(0, 5) == 0) ? 32'h0 :
                          $urandom_range(0, 32'h0040_0000) - 32'h0020_0000,
                      $urandom_range(0, 2000) - 1000,
                      iu, il, du, dl, $urandom_range(0, 32'h0000_4000));
        end
    endtask

    task automatic random_items(int count);
        logic [31:0] sp, ms;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                sp = $urandom;
                ms = $urandom;
            end else begin
                sp = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
                ms = sp + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            end
            send_item(sp, ms, next_stamp());
        end
    endtask

    task automatic test_reset_state();
        // all gains zero: drive zero, equal to both limits so not clamped
        send_item(32'h0001_0000, 32'h0, 24'd0);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 24'd9000);
    endtask

    task automatic test_interval_cases();
        set_gains(32'h0001_0000, 32'h0001_0000, 32'h0000_0100, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        stamp_gen = 24'd0;
        send_item(32'h0002_0000, 32'h0001_0000, 24'd500000);
        send_item(32'h0002_0000, 32'h0001_8000, 24'd491000);
        send_item(32'h0002_0000, 32'h0001_8000, 24'd491000);     // zero interval
        send_item(32'h0002_0000, 32'h0001_C000, 24'd41000);      // exactly the longest
        send_item(32'h0002_0000, 32'h0001_C000, 24'd40999);      // one tick
        send_item(32'h0002_0000, 32'h0001_0000, 24'hFFFF00);     // wrap
        send_item(32'h0002_0000, 32'h0001_0000, 24'hFFFFFF);     // wrap to reload
        send_item(32'h0002_0000, 32'h0001_0000, 24'd0);          // too long
        send_item(32'h0002_0000, 32'h0001_0000, 24'hFFFFFF);
    endtask

    task automatic test_field_extremes();
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 24'hFFF000);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 24'hFFE000);
        send_item(32'h8000_0000, 32'h8000_0000, 24'hFFD000);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFC000);
        set_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 24'hFFB000);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 24'hFFB001);
        send_item(32'h0, 32'h0, 24'hFFA000);
    endtask

    task automatic test_limit_cases();
        // crossed integral and drive limits: the lower one wins
        set_gains(32'h0001_0000, 32'h0010_0000, 32'h0, 32'hFFFF_0000, 32'h0001_0000,
                  32'hFFF0_0000, 32'h0010_0000, 32'h0000_1000);
        send_item(32'h0001_0000, 32'h0, 24'd90000);
        send_item(32'h8000_0000, 32'h0, 24'd81000);
        // zero sum keeps the offset off, a value on the limit is not clamped
        set_gains(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'hFFFD_0000,
                  32'h0001_0000);
        send_item(32'h0001_0000, 32'h0001_0000, 24'd72000);
        send_item(32'h0002_0000, 32'h0, 24'd63000);
        send_item(32'h0, 32'h0002_0000, 24'd54000);
        send_item(32'h0005_0000, 32'h0, 24'd45000);
    endtask

    task automatic test_random();
        int ph;
        for (ph = 0; ph < 8; ph++) begin
            random_gains(ph == 3 || ph == 6);
            random_items(90);
        end
    endtask

    task automatic test_backpressure();
        random_gains(1'b0);
        hold_left = 400;
        random_items(30);
    endtask

    task automatic test_no_idle();
        random_gains(1'b0);
        idle_en = 1'b0;
        random_items(80);
    endtask

    initial begin
        foreach (gain_cfg[k]) gain_cfg[k] = 0;
        prev_stamp   = '0;
        prev_meas    = 0;
        integ        = 0;
        fail_count   = 0;
        cycle_count  = 0;
        idle_en      = 1'b1;
        hold_left    = 0;
        stall_left   = 0;
        stamp_gen    = '0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_setpoint   = '0;
        i_measured   = '0;
        i_tick_stamp = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_interval_cases();
        test_field_extremes();
        test_limit_cases();
        test_random();
        test_backpressure();
        test_no_idle();
        drain();

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
